FILE: src/fds_pkg.sv
`timescale 1ns / 1ps

package fds_pkg;

    localparam int WINDOW   = 16;
    localparam int SAMPLE_W = 18;
    localparam int DELTA_W  = 32;
    localparam int TIME_W   = 48;
    localparam int PTR_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W    = $clog2(WINDOW + 1);
    localparam int SUM_W    = SAMPLE_W + $clog2(WINDOW);
    localparam int DIV_CNT_W = $clog2(SUM_W);
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_OUTLIER_LIMIT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_DURATION = 1'd1;

    localparam logic [SAMPLE_W-1:0] OUTLIER_LIMIT_RST = 18'd200000;
    localparam logic [SAMPLE_W-1:0] INIT_DURATION_RST = 18'd30000;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_NEWEST,
        ST_OLDEST,
        ST_START,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic                we;
        logic [PTR_W-1:0]    waddr;
        logic [SAMPLE_W-1:0] wdata;
        logic [PTR_W-1:0]    raddr;
    } ring_req_t;

    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] dividend;
        logic [CNT_W-1:0] divisor;
    } div_cmd_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [SUM_W-1:0] quotient;
    } div_status_t;

endpackage

FILE: src/fds_ring.sv
`timescale 1ns / 1ps

module fds_ring (
    input  logic                            clk,
    input  fds_pkg::ring_req_t              req,
    output logic [fds_pkg::SAMPLE_W-1:0]    rdata
);
    import fds_pkg::*;

    logic [SAMPLE_W-1:0] ram_reg [WINDOW];
    logic [SAMPLE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            ram_reg[req.waddr] <= req.wdata;
        end
        rdata_reg <= ram_reg[req.raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/fds_divider.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module fds_divider (
    input  logic                 clk,
    input  logic                 rst_n,
    input  fds_pkg::div_cmd_t    cmd,
    output fds_pkg::div_status_t status
);
    import fds_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [SUM_W-1:0]     quo_reg;
    logic [CNT_W-1:0]     rem_reg;
    logic [CNT_W-1:0]     dvs_reg;

    logic [CNT_W:0]   trial;
    logic             fits;
    logic [CNT_W:0]   diff;
    logic [CNT_W-1:0] rem_next;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[SUM_W-1]};
        fits     = (trial >= {1'b0, dvs_reg});
        diff     = trial - {1'b0, dvs_reg};
        // remainder stays below the divisor, so it fits back in CNT_W bits
        rem_next = fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == '0);
            if (cmd.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(SUM_W - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            quo_reg <= cmd.dividend;
            rem_reg <= '0;
            dvs_reg <= cmd.divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[SUM_W-2:0], fits};
            rem_reg <= rem_next;
        end
    end

    assign status.busy     = busy_reg;
    assign status.done     = done_reg;
    assign status.quotient = quo_reg;

endmodule

FILE: src/frame_duration_smoother.sv
`timescale 1ns / 1ps

// Frame duration smoother. Each input beat carries one measured frame duration
// in microseconds; a duration above outlier_limit is replaced by the newest
// stored sample. Samples go into a 16-entry history RAM and the block returns
// the truncated mean of the filled entries, the saturating sum of all means
// so far, and the last nonzero mean. After a frame is accepted the block
// reads the newest and then the oldest RAM entry, writes the new sample
// back, starts the bit-serial divider on the 22-bit sum, captures the
// quotient, and then loads the output register, which raises out_valid,
// while it returns to idle. The load waits while the output register still
// holds an untaken result. A new frame is taken as soon as the previous one
// has moved to the output register, even if that result has not been taken
// yet. After reset the block seeds the first RAM entry before in_ready
// rises. Writing initial_duration restarts the history; elapsed_time is kept.
module frame_duration_smoother (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [fds_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fds_pkg::SAMPLE_W-1:0]       cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [fds_pkg::DELTA_W-1:0]        frame_delta,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [fds_pkg::SAMPLE_W-1:0]       predicted_duration,
    output logic [fds_pkg::TIME_W-1:0]         elapsed_time,
    output logic [fds_pkg::SAMPLE_W-1:0]       frame_time
);
    import fds_pkg::*;

    state_t state_reg;
    state_t state_next;

    logic [SAMPLE_W-1:0] limit_reg;
    logic [SAMPLE_W-1:0] init_dur_reg;
    logic [PTR_W-1:0]    wpos_reg;
    logic [CNT_W-1:0]    fill_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [TIME_W-1:0]   total_reg;
    logic [SAMPLE_W-1:0] held_reg;
    logic                outlier_reg;
    logic [SAMPLE_W-1:0] delta_reg;
    logic [SAMPLE_W-1:0] sample_reg;
    logic [SAMPLE_W-1:0] mean_reg;
    logic                out_valid_reg;
    logic [SAMPLE_W-1:0] out_pred_reg;
    logic [TIME_W-1:0]   out_time_reg;
    logic [SAMPLE_W-1:0] out_frame_reg;

    ring_req_t           ring_req;
    logic [SAMPLE_W-1:0] ring_rdata;
    div_cmd_t            div_cmd;
    div_status_t         div_status;

    logic                seed_wr;
    logic                accept;
    logic                out_free;
    logic                load_out;
    logic                full;
    logic [PTR_W-1:0]    wpos_inc;
    logic [TIME_W:0]     total_sum;
    logic [TIME_W-1:0]   total_next;
    logic [SUM_W-1:0]    sum_next;

    fds_ring u_ring (
        .clk   (clk),
        .req   (ring_req),
        .rdata (ring_rdata)
    );

    fds_divider u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (div_cmd),
        .status (div_status)
    );

    assign seed_wr  = cfg_write && (cfg_index == REG_INIT_DURATION);
    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign full     = (fill_reg == CNT_W'(WINDOW));
    assign wpos_inc = (wpos_reg == PTR_W'(WINDOW - 1)) ? '0 : wpos_reg + 1'b1;

    always_comb
    begin
        sum_next   = sum_reg - (full ? SUM_W'(ring_rdata) : '0) + SUM_W'(sample_reg);
        total_sum  = {1'b0, total_reg} + (TIME_W + 1)'(mean_reg);
        total_next = total_sum[TIME_W] ? '1 : total_sum[TIME_W-1:0];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT:   state_next = ST_IDLE;
            ST_IDLE:   if (in_valid) state_next = ST_NEWEST;
            ST_NEWEST: state_next = ST_OLDEST;
            ST_OLDEST: state_next = ST_START;
            ST_START:  state_next = ST_DIV;
            ST_DIV:    if (div_status.done) state_next = ST_DONE;
            ST_DONE:   if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_INIT;
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready         = 1'b0;
        load_out         = 1'b0;
        ring_req.we      = 1'b0;
        ring_req.waddr   = '0;
        ring_req.wdata   = cfg_data;
        ring_req.raddr   = wpos_reg;
        div_cmd.start    = 1'b0;
        div_cmd.dividend = sum_reg;
        div_cmd.divisor  = fill_reg;
        unique case (state_reg)
            ST_INIT:
            begin
                ring_req.we    = 1'b1;
                ring_req.wdata = init_dur_reg;
            end
            ST_IDLE:   in_ready = 1'b1;
            ST_NEWEST: ring_req.raddr = wpos_inc;
            ST_OLDEST:
            begin
                ring_req.we    = 1'b1;
                ring_req.waddr = wpos_inc;
                ring_req.wdata = sample_reg;
            end
            ST_START:  div_cmd.start = 1'b1;
            ST_DIV:    ;
            ST_DONE:   load_out = out_free;
            default:   ;
        endcase
        // seed write wins the RAM port; the user must issue it only while idle, the block does not enforce this
        if (seed_wr)
        begin
            ring_req.we    = 1'b1;
            ring_req.waddr = '0;
            ring_req.wdata = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            limit_reg     <= OUTLIER_LIMIT_RST;
            init_dur_reg  <= INIT_DURATION_RST;
            wpos_reg      <= '0;
            fill_reg      <= CNT_W'(1);
            sum_reg       <= SUM_W'(INIT_DURATION_RST);
            total_reg     <= '0;
            held_reg      <= INIT_DURATION_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_write && (cfg_index == REG_OUTLIER_LIMIT))
            begin
                limit_reg <= cfg_data;
            end

            if (seed_wr)
            begin
                init_dur_reg <= cfg_data;
                wpos_reg     <= '0;
                fill_reg     <= CNT_W'(1);
                sum_reg      <= SUM_W'(cfg_data);
                held_reg     <= cfg_data;
            end
            else if (state_reg == ST_OLDEST)
            begin
                wpos_reg <= wpos_inc;
                sum_reg  <= sum_next;
                if (!full)
                begin
                    fill_reg <= fill_reg + 1'b1;
                end
            end
            else if (load_out && (mean_reg != '0))
            begin
                held_reg <= mean_reg;
            end

            if (load_out)
            begin
                total_reg     <= total_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            outlier_reg <= (frame_delta > DELTA_W'(limit_reg));
            delta_reg   <= frame_delta[SAMPLE_W-1:0];
        end
        if (state_reg == ST_NEWEST)
        begin
            sample_reg <= outlier_reg ? ring_rdata : delta_reg;
        end
        if ((state_reg == ST_DIV) && div_status.done)
        begin
            // mean never exceeds the largest sample
            mean_reg <= div_status.quotient[SAMPLE_W-1:0];
        end
        if (load_out)
        begin
            out_pred_reg  <= mean_reg;
            out_time_reg  <= total_next;
            out_frame_reg <= (mean_reg != '0) ? mean_reg : held_reg;
        end
    end

    assign out_valid          = out_valid_reg;
    assign predicted_duration = out_pred_reg;
    assign elapsed_time       = out_time_reg;
    assign frame_time         = out_frame_reg;

endmodule

FILE: tb/fds_checker.sv
`timescale 1ns / 1ps

module fds_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [fds_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fds_pkg::SAMPLE_W-1:0]  cfg_data,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic [fds_pkg::DELTA_W-1:0]   frame_delta,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [fds_pkg::SAMPLE_W-1:0]  predicted_duration,
    input  logic [fds_pkg::TIME_W-1:0]    elapsed_time,
    input  logic [fds_pkg::SAMPLE_W-1:0]  frame_time,
    output int                            mismatches,
    output int                            outstanding
);
    import fds_pkg::*;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    typedef struct {
        logic [SAMPLE_W-1:0] duration;
        logic [TIME_W-1:0]   elapsed;
        logic [SAMPLE_W-1:0] held;
    } frame_result_t;

    // predictor state
    logic [SAMPLE_W-1:0] history [WINDOW];
    logic [PTR_W-1:0]    newest;
    logic [CNT_W-1:0]    filled;
    logic [SUM_W-1:0]    history_sum;
    logic [TIME_W-1:0]   elapsed_acc;
    logic [SAMPLE_W-1:0] held_time;
    logic [SAMPLE_W-1:0] limit_reg;
    logic [SAMPLE_W-1:0] seed_reg;

    frame_result_t expected_frames [$];
    int mismatch_count = 0;
    int pending_count = 0;

    assign mismatches  = mismatch_count;
    assign outstanding = pending_count;

    task automatic report_mismatch(input string what, input logic [TIME_W-1:0] want,
                                   input logic [TIME_W-1:0] got);
        mismatch_count++;
        $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what, want, got);
    endtask

    task automatic restart_history();
        history[0]  = seed_reg;
        newest      = '0;
        filled      = CNT_W'(1);
        history_sum = SUM_W'(seed_reg);
        held_time   = seed_reg;
    endtask

    function automatic frame_result_t smooth_frame(input logic [DELTA_W-1:0] delta);
        frame_result_t       res;
        logic [SAMPLE_W-1:0] sample;
        logic [PTR_W-1:0]    slot;
        logic [SUM_W-1:0]    quotient;
        logic [SAMPLE_W-1:0] mean;

        // outliers repeat the newest stored sample
        if (delta > DELTA_W'(limit_reg))
            sample = history[newest];
        else
            sample = delta[SAMPLE_W-1:0];

        slot = (newest == PTR_W'(WINDOW - 1)) ? '0 : newest + 1'b1;
        if (filled < CNT_W'(WINDOW))
            filled = filled + 1'b1;
        else
            history_sum = history_sum - SUM_W'(history[slot]);
        history[slot] = sample;
        history_sum   = history_sum + SUM_W'(sample);
        newest        = slot;

        quotient = history_sum / SUM_W'(filled);
        mean     = quotient[SAMPLE_W-1:0];

        if (TIME_MAX - elapsed_acc < TIME_W'(mean))
            elapsed_acc = TIME_MAX;
        else
            elapsed_acc = elapsed_acc + TIME_W'(mean);

        if (mean != '0)
            held_time = mean;

        res.duration = mean;
        res.elapsed  = elapsed_acc;
        res.held     = held_time;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        frame_result_t want;
        if (!rst_n)
        begin
            limit_reg   = OUTLIER_LIMIT_RST;
            seed_reg    = INIT_DURATION_RST;
            elapsed_acc = '0;
            restart_history();
            expected_frames.delete();
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == REG_OUTLIER_LIMIT)
                    limit_reg = cfg_data;
                else if (cfg_index == REG_INIT_DURATION)
                begin
                    seed_reg = cfg_data;
                    restart_history();
                end
            end

            if (out_valid && out_ready)
            begin
                if (expected_frames.size() == 0)
                    report_mismatch("result beat with nothing pending", '0,
                                    TIME_W'(predicted_duration));
                else
                begin
                    want = expected_frames.pop_front();
                    if (predicted_duration !== want.duration)
                        report_mismatch("predicted_duration", TIME_W'(want.duration),
                                        TIME_W'(predicted_duration));
                    if (elapsed_time !== want.elapsed)
                        report_mismatch("elapsed_time", want.elapsed, elapsed_time);
                    if (frame_time !== want.held)
                        report_mismatch("frame_time", TIME_W'(want.held),
                                        TIME_W'(frame_time));
                end
            end

            if (in_valid && in_ready)
                expected_frames.push_back(smooth_frame(frame_delta));
        end
        pending_count = expected_frames.size();
    end

endmodule

FILE: tb/frame_duration_smoother_tb.sv
`timescale 1ns / 1ps

module frame_duration_smoother_tb;
    import fds_pkg::*;

    localparam int LONG_HOLD    = 160;
    localparam int RANDOM_RUNS  = 12;
    localparam int RUN_FRAMES   = 95;
    localparam int SAMPLE_MAX   = (1 << SAMPLE_W) - 1;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [SAMPLE_W-1:0]  cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    logic [DELTA_W-1:0]   frame_delta;
    logic                 out_valid;
    logic                 out_ready;
    logic [SAMPLE_W-1:0]  predicted_duration;
    logic [TIME_W-1:0]    elapsed_time;
    logic [SAMPLE_W-1:0]  frame_time;

    int                   mismatches;
    int                   outstanding;
    logic                 hold_toggle;
    logic [SAMPLE_W-1:0]  cur_limit;

    frame_duration_smoother dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_write          (cfg_write),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .frame_delta        (frame_delta),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .predicted_duration (predicted_duration),
        .elapsed_time       (elapsed_time),
        .frame_time         (frame_time)
    );

    fds_checker checker_i (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_write          (cfg_write),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .frame_delta        (frame_delta),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .predicted_duration (predicted_duration),
        .elapsed_time       (elapsed_time),
        .frame_time         (frame_time),
        .mismatches         (mismatches),
        .outstanding        (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // result side: stall modes change after a random span; a toggle on
    // hold_toggle asks for one long hold-off
    initial
    begin
        logic seen_toggle;
        int   mode;
        int   span;
        int   cyc;
        int   k;
        out_ready   = 1'b0;
        seen_toggle = 1'b0;
        mode        = 0;
        span        = 0;
        cyc         = 0;
        forever
        begin
            @(negedge clk);
            cyc++;
            if (hold_toggle !== seen_toggle)
            begin
                seen_toggle = hold_toggle;
                out_ready <= 1'b0;
                for (k = 0; k < LONG_HOLD; k++)
                    @(negedge clk);
            end
            if (span == 0)
            begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(8, 120);
            end
            span--;
            case (mode)
                0:       out_ready <= 1'b1;
                1:       out_ready <= 1'($urandom_range(0, 1));
                2:       out_ready <= ($urandom_range(0, 4) == 0);
                default: out_ready <= ((cyc % 7) < 3);
            endcase
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SAMPLE_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == REG_OUTLIER_LIMIT)
            cur_limit = val;
        @(negedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    // leaves valid high; the caller drops it when a gap follows
    task automatic send_frame(input logic [DELTA_W-1:0] d);
        in_valid    <= 1'b1;
        frame_delta <= d;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    function automatic logic [DELTA_W-1:0] pick_delta();
        int unsigned lim;
        lim = cur_limit;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return $urandom_range(0, lim);
            5:             return $urandom_range(0, 15);
            6:             return lim + 1;
            7:             return $urandom;
            8:             return $urandom_range(lim, SAMPLE_MAX);
            default:       return 32'hFFFF_FFFF - $urandom_range(0, 3);
        endcase
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_reg_value();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return SAMPLE_W'(1);
            2:       return SAMPLE_W'(SAMPLE_MAX);
            3:       return SAMPLE_W'($urandom_range(1, 64));
            default: return SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
        endcase
    endfunction

    task automatic run_frames(input int count);
        int burst;
        int gap;
        int i;
        burst = $urandom_range(1, 12);
        for (i = 0; i < count; i++)
        begin
            send_frame(pick_delta());
            burst--;
            if (burst == 0)
            begin
                burst = $urandom_range(1, 12);
                gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
                if (gap > 0)
                begin
                    in_valid <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
            end
        end
        drain_results();
    endtask

    initial
    begin
        int run;
        int which;
        rst_n       = 1'b0;
        cfg_write   = 1'b0;
        cfg_index   = REG_OUTLIER_LIMIT;
        cfg_data    = '0;
        in_valid    = 1'b0;
        frame_delta = '0;
        hold_toggle = 1'b0;
        cur_limit   = OUTLIER_LIMIT_RST;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // reset settings: limit edges and outliers, with the result side held
        // off long enough to back up the input
        hold_toggle <= 1'b1;
        send_frame(32'd0);
        send_frame(32'd200000);
        send_frame(32'd200001);
        send_frame(32'hFFFF_FFFF);
        send_frame(32'd262143);
        send_frame(32'd1);
        send_frame(32'd100000);
        drain_results();

        // tiny seed followed by zeros drives the mean to zero
        write_reg(REG_OUTLIER_LIMIT, SAMPLE_W'(SAMPLE_MAX));
        write_reg(REG_INIT_DURATION, 18'd5);
        repeat (6) send_frame(32'd0);
        send_frame(32'd262143);
        send_frame(32'h0004_0000);
        drain_results();

        // zero limit: anything nonzero is an outlier
        write_reg(REG_OUTLIER_LIMIT, '0);
        write_reg(REG_INIT_DURATION, '0);
        send_frame(32'd0);
        send_frame(32'd7);
        send_frame(32'hFFFF_FFFF);
        drain_results();

        for (run = 0; run < RANDOM_RUNS; run++)
        begin
            if (run == 0)
            begin
                write_reg(REG_OUTLIER_LIMIT, 18'd1);
                write_reg(REG_INIT_DURATION, SAMPLE_W'(SAMPLE_MAX));
            end
            else
            begin
                which = $urandom_range(0, 3);
                if (which == 0 || which == 2)
                    write_reg(REG_OUTLIER_LIMIT, pick_reg_value());
                if (which == 1 || which == 2)
                    write_reg(REG_INIT_DURATION, pick_reg_value());
            end
            if ($urandom_range(0, 2) == 0)
                hold_toggle <= ~hold_toggle;
            run_frames(RUN_FRAMES);
        end

        repeat (40) @(negedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
